/* rtl/speed_pulse_period_accumulator_unit_defines.svh */
// Assertion macros shared by the speed pulse period accumulator RTL.
`ifndef SPEED_PULSE_PERIOD_ACCUMULATOR_UNIT_DEFINES_SVH
`define SPEED_PULSE_PERIOD_ACCUMULATOR_UNIT_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("speed pulse accumulator: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define SPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("speed pulse accumulator: next-cycle check failed");

`endif

/* rtl/spa_pkg.sv */
package spa_pkg;

  localparam int unsigned CAP_W    = 16;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned CFG_W    = 32;

  // Captures below this value are taken as post-wrap when an overflow is pending.
  localparam logic [CAP_W-1:0] WRAP_WINDOW = 16'h1000;
  localparam logic [CAP_W-1:0] NOISE_MIN_RESET = 16'd20;
  localparam logic [CAP_W-1:0] TEETH_MAX = 16'hFFFF;

  typedef enum logic {
    FUNC_CAPTURE = 1'b0,
    FUNC_COLLECT = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    CFG_TIME_THRESHOLD = 2'd0,
    CFG_NOISE_MIN      = 2'd1,
    CFG_MIRROR_ENABLE  = 2'd2
  } cfg_idx_t;

endpackage

/* rtl/speed_pulse_period_accumulator_unit.sv */
// Speed sensor period accumulator. Each capture transfer joins a 16-bit timer
// capture and its overflow count into a 32-bit timestamp (adding one overflow
// when an overflow is pending and the capture looks post-wrap), returns the
// period since the last accepted edge, and rejects periods shorter than the
// noise minimum. Accepted edges bump a saturating tooth count and a saturating
// time sum; sample_ready rises once the sum exceeds the threshold. A collect
// transfer returns the accumulators and the flag and clears them. The block
// takes one item per cycle unless out_ready is low: an input register feeds
// the logic into the result register, so each transfer is held in the input
// register and then in the result register, where its result is presented.
// Configuration writes take effect the cycle after cfg_we.
`include "speed_pulse_period_accumulator_unit_defines.svh"

module speed_pulse_period_accumulator_unit (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  spa_pkg::cfg_idx_t   cfg_index,
  input  logic [31:0]         cfg_wdata,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  spa_pkg::func_t      in_func,
  input  logic [15:0]         in_capture_value,
  input  logic [15:0]         in_overflow_count,
  input  logic                in_overflow_close,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_edge_accepted,
  output logic [31:0]         out_period,
  output logic                out_sample_ready,
  output logic                out_mirror_pulse,
  output logic [15:0]         out_teeth_count,
  output logic [31:0]         out_time_sum
);
  import spa_pkg::*;

  // configuration registers
  logic [STAMP_W-1:0] time_threshold_r;
  logic [CAP_W-1:0]   noise_min_r;
  logic               mirror_en_r;

  // input stage
  logic               s1_valid_r;
  func_t              s1_func_r;
  logic [CAP_W-1:0]   s1_cap_r;
  logic [CAP_W-1:0]   s1_ovf_r;
  logic               s1_close_r;

  // edge state
  logic [CAP_W-1:0]   last_capture_r, last_capture_nxt;
  logic [CAP_W-1:0]   last_overflow_r, last_overflow_nxt;
  logic [STAMP_W-1:0] last_timestamp_r, last_timestamp_nxt;
  logic [CAP_W-1:0]   teeth_acc_r, teeth_acc_nxt;
  logic [STAMP_W-1:0] time_acc_r, time_acc_nxt;
  logic               ready_flag_r, ready_flag_nxt;

  // result stage
  logic               out_valid_r;
  logic               out_edge_accepted_r, out_edge_accepted_nxt;
  logic [STAMP_W-1:0] out_period_r, out_period_nxt;
  logic               out_sample_ready_r;
  logic               out_mirror_pulse_r, out_mirror_pulse_nxt;
  logic [CAP_W-1:0]   out_teeth_count_r;
  logic [STAMP_W-1:0] out_time_sum_r;

  logic               advance;
  logic               wrap;
  logic [STAMP_W-1:0] stamp;
  logic [STAMP_W-1:0] period;
  logic               accept;
  logic [STAMP_W:0]   sum_wide;
  logic [STAMP_W-1:0] sum_sat;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_threshold_r <= '0;
      noise_min_r      <= NOISE_MIN_RESET;
      mirror_en_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_THRESHOLD: time_threshold_r <= cfg_wdata;
        CFG_NOISE_MIN:      noise_min_r      <= cfg_wdata[CAP_W-1:0];
        CFG_MIRROR_ENABLE:  mirror_en_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r  <= in_func;
      s1_cap_r   <= in_capture_value;
      s1_ovf_r   <= in_overflow_count;
      s1_close_r <= in_overflow_close;
    end
  end

  // A pending overflow counts when the capture is near zero, or when it went
  // backwards while the overflow count did not move.
  assign wrap = s1_close_r && ((s1_cap_r < WRAP_WINDOW) ||
                ((s1_cap_r < last_capture_r) && (s1_ovf_r == last_overflow_r)));
  assign stamp    = {s1_ovf_r + CAP_W'(wrap), s1_cap_r};
  assign period   = stamp - last_timestamp_r;
  assign accept   = period >= {{(STAMP_W-CAP_W){1'b0}}, noise_min_r};
  assign sum_wide = {1'b0, time_acc_r} + {1'b0, period};
  assign sum_sat  = sum_wide[STAMP_W] ? '1 : sum_wide[STAMP_W-1:0];

  always_comb begin
    last_capture_nxt      = last_capture_r;
    last_overflow_nxt     = last_overflow_r;
    last_timestamp_nxt    = last_timestamp_r;
    teeth_acc_nxt         = teeth_acc_r;
    time_acc_nxt          = time_acc_r;
    ready_flag_nxt        = ready_flag_r;
    out_edge_accepted_nxt = 1'b0;
    out_period_nxt        = '0;
    out_mirror_pulse_nxt  = 1'b0;
    unique case (s1_func_r)
      FUNC_COLLECT: begin
        teeth_acc_nxt  = '0;
        time_acc_nxt   = '0;
        ready_flag_nxt = 1'b0;
      end
      FUNC_CAPTURE: begin
        out_period_nxt = period;
        if (accept) begin
          last_capture_nxt      = s1_cap_r;
          last_overflow_nxt     = s1_ovf_r;
          last_timestamp_nxt    = stamp;
          teeth_acc_nxt         = (teeth_acc_r == TEETH_MAX) ? teeth_acc_r
                                                             : teeth_acc_r + 1'b1;
          time_acc_nxt          = sum_sat;
          ready_flag_nxt        = ready_flag_r || (sum_sat > time_threshold_r);
          out_edge_accepted_nxt = 1'b1;
          out_mirror_pulse_nxt  = mirror_en_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_capture_r   <= '0;
      last_overflow_r  <= '0;
      last_timestamp_r <= '0;
      teeth_acc_r      <= '0;
      time_acc_r       <= '0;
      ready_flag_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (advance) begin
        last_capture_r   <= last_capture_nxt;
        last_overflow_r  <= last_overflow_nxt;
        last_timestamp_r <= last_timestamp_nxt;
        teeth_acc_r      <= teeth_acc_nxt;
        time_acc_r       <= time_acc_nxt;
        ready_flag_r     <= ready_flag_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ready) begin
        out_valid_r      <= 1'b0;
      end
    end
  end

  // A collect reports the state before clearing; a capture reports it after.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_edge_accepted_r <= out_edge_accepted_nxt;
      out_period_r        <= out_period_nxt;
      out_mirror_pulse_r  <= out_mirror_pulse_nxt;
      out_sample_ready_r  <= (s1_func_r == FUNC_COLLECT) ? ready_flag_r : ready_flag_nxt;
      out_teeth_count_r   <= (s1_func_r == FUNC_COLLECT) ? teeth_acc_r : teeth_acc_nxt;
      out_time_sum_r      <= (s1_func_r == FUNC_COLLECT) ? time_acc_r : time_acc_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_edge_accepted = out_edge_accepted_r;
  assign out_period        = out_period_r;
  assign out_sample_ready  = out_sample_ready_r;
  assign out_mirror_pulse  = out_mirror_pulse_r;
  assign out_teeth_count   = out_teeth_count_r;
  assign out_time_sum      = out_time_sum_r;

  `SPA_ASSERT_NEXT(a_collect_clears, clk, rst_n,
                   advance && (s1_func_r == FUNC_COLLECT),
                   (teeth_acc_r == '0) && (time_acc_r == '0) && !ready_flag_r)
  `SPA_ASSERT_NEXT(a_teeth_monotonic, clk, rst_n,
                   advance && (s1_func_r == FUNC_CAPTURE),
                   teeth_acc_r >= $past(teeth_acc_r))
  `SPA_ASSERT_SAME(a_mirror_needs_accept, clk, rst_n,
                   out_valid_r && out_mirror_pulse_r,
                   out_edge_accepted_r && mirror_en_r)
  `SPA_ASSERT_SAME(a_stall_only_when_full, clk, rst_n,
                   !in_ready,
                   s1_valid_r && out_valid_r && !out_ready)

endmodule
